/* rtl/rmth_pkg.sv */
`timescale 1ns / 1ps
// shared constants and helpers for the two-heap running median
// no dependencies
package rmth_pkg;

   localparam int HEAP_DEPTH = 512;
   localparam int ADDR_W     = $clog2(HEAP_DEPTH);
   localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
   localparam int CNT_W      = $clog2(2 * HEAP_DEPTH + 1);
   localparam int SAMPLE_W   = 32;
   localparam int MED_W      = SAMPLE_W + 1;
   localparam int IN_TDATA_W  = 32;
   localparam int OUT_TDATA_W = 48;
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(2 * HEAP_DEPTH);

   localparam logic HEAP_LOWER = 1'b0;
   localparam logic HEAP_UPPER = 1'b1;

   // max heap for the lower half, min heap for the upper half
   function automatic logic ranks_above(input logic signed [SAMPLE_W-1:0] a,
                                        input logic signed [SAMPLE_W-1:0] b,
                                        input logic heap);
      ranks_above = (heap == HEAP_LOWER) ? (a > b) : (a < b);
   endfunction

endpackage

/* rtl/running_median_two_heaps.sv */
`timescale 1ns / 1ps
// running median top level: controller and both heap memories
// depends on rmth_pkg
//
// Each word takes one 32-bit signed sample and returns twice the running median
// (one fraction bit), the stored count and a dropped flag once 1024 samples are
// held. Work is serial in one sift unit over two 512-entry synchronous memories:
// an insert sifts up over at most nine levels, reading the parent then comparing
// and writing, and when a top moves across it sifts down the other heap, reading
// the left child, then the right child, then comparing. One word is in work at a
// time; a finished result waits in the output register while the next word is accepted.
module running_median_two_heaps (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // median_doubled[32:0], sample_count[43:33], zero
   output logic        rsp_tuser    // dropped
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UP_RD  = 3'd1;
   localparam logic [2:0] ST_UP_CMP = 3'd2;
   localparam logic [2:0] ST_DN_RL  = 3'd3;
   localparam logic [2:0] ST_DN_RR  = 3'd4;
   localparam logic [2:0] ST_DN_CMP = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   localparam int AW = rmth_pkg::ADDR_W;
   localparam int SW = rmth_pkg::SIZE_W;
   localparam int CW = rmth_pkg::CNT_W;
   localparam int DW = rmth_pkg::SAMPLE_W;
   localparam int MW = rmth_pkg::MED_W;

   logic [DW-1:0] lower_mem [rmth_pkg::HEAP_DEPTH];
   logic [DW-1:0] upper_mem [rmth_pkg::HEAP_DEPTH];

   logic [2:0]           state_ff, state_in;
   logic                 sel_ff, sel_in, rd_sel_ff;
   logic [AW-1:0]        idx_ff, idx_in;
   logic signed [DW-1:0] val_ff, val_in, sample_ff, sample_in, lbuf_ff, lbuf_in;
   logic                 pend_ff, pend_in, has_r_ff, has_r_in, drop_ff, drop_in;
   logic [SW-1:0]        lsize_ff, lsize_in, usize_ff, usize_in;
   logic signed [DW-1:0] ltop_ff, utop_ff;
   logic [DW-1:0]        lo_rd_ff, up_rd_ff;
   logic                 out_valid_ff, out_valid_in, out_drop_ff, out_drop_in;
   logic [MW-1:0]        out_med_ff, out_med_in;
   logic [CW-1:0]        out_cnt_ff, out_cnt_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [DW-1:0]        wr_data;
   logic signed [DW-1:0] rdata, s, bv;
   logic [CW-1:0]        count, l_idx, r_idx, n_size;
   logic [AW-1:0]        parent, best;
   logic [MW-1:0]        med;

   assign rdata  = rd_sel_ff ? up_rd_ff : lo_rd_ff;
   assign s      = req_tdata[DW-1:0];
   assign count  = CW'(lsize_ff) + CW'(usize_ff);
   assign parent = (idx_ff - AW'(1)) >> 1;
   assign l_idx  = {1'b0, idx_ff, 1'b1};
   assign r_idx  = l_idx + CW'(1);
   assign n_size = sel_ff ? CW'(usize_ff) : CW'(lsize_ff);

   always_comb begin
      if (lsize_ff == usize_ff) begin
         med = {ltop_ff[DW-1], ltop_ff} + {utop_ff[DW-1], utop_ff};
      end else if (lsize_ff > usize_ff) begin
         med = {ltop_ff, 1'b0};
      end else begin
         med = {utop_ff, 1'b0};
      end
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      sample_in    = sample_ff;
      lbuf_in      = lbuf_ff;
      pend_in      = pend_ff;
      has_r_in     = has_r_ff;
      drop_in      = drop_ff;
      lsize_in     = lsize_ff;
      usize_in     = usize_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_med_in   = out_med_ff;
      out_cnt_in   = out_cnt_ff;
      out_drop_in  = out_drop_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = val_ff;
      rd_addr      = parent;
      bv           = val_ff;
      best         = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               drop_in   = 1'b0;
               pend_in   = 1'b0;
               sample_in = s;
               val_in    = s;
               state_in  = ST_UP_RD;
               if (count == rmth_pkg::MAX_COUNT) begin
                  drop_in  = 1'b1;
                  state_in = ST_DONE;
               end else if (count == '0) begin
                  sel_in = rmth_pkg::HEAP_LOWER;
               end else if (lsize_ff == usize_ff) begin
                  sel_in = (s < ltop_ff) ? rmth_pkg::HEAP_LOWER : rmth_pkg::HEAP_UPPER;
               end else if (lsize_ff > usize_ff) begin
                  sel_in = rmth_pkg::HEAP_UPPER;
                  if (!(s > ltop_ff)) begin
                     val_in  = ltop_ff;
                     pend_in = 1'b1;
                  end
               end else begin
                  sel_in = rmth_pkg::HEAP_LOWER;
                  if (!(s < utop_ff)) begin
                     val_in  = utop_ff;
                     pend_in = 1'b1;
                  end
               end
               if (count != rmth_pkg::MAX_COUNT) begin
                  if (sel_in == rmth_pkg::HEAP_UPPER) begin
                     idx_in   = usize_ff[AW-1:0];
                     usize_in = usize_ff + SW'(1);
                  end else begin
                     idx_in   = lsize_ff[AW-1:0];
                     lsize_in = lsize_ff + SW'(1);
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (idx_ff == '0) begin
               wr_en = 1'b1;
               if (pend_ff) begin
                  sel_in   = !sel_ff;
                  val_in   = sample_ff;
                  state_in = ST_DN_RL;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (rmth_pkg::ranks_above(val_ff, rdata, sel_ff)) begin
               wr_data  = rdata;
               idx_in   = parent;
               state_in = ST_UP_RD;
            end else if (pend_ff) begin
               sel_in   = !sel_ff;
               val_in   = sample_ff;
               idx_in   = '0;
               state_in = ST_DN_RL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DN_RL: begin
            rd_addr = l_idx[AW-1:0];
            if (l_idx >= n_size) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DN_RR;
            end
         end
         ST_DN_RR: begin
            rd_addr  = r_idx[AW-1:0];
            lbuf_in  = rdata;
            has_r_in = r_idx < n_size;
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (rmth_pkg::ranks_above(lbuf_ff, bv, sel_ff)) begin
               best = l_idx[AW-1:0];
               bv   = lbuf_ff;
            end
            if (has_r_ff && rmth_pkg::ranks_above(rdata, bv, sel_ff)) begin
               best = r_idx[AW-1:0];
               bv   = rdata;
            end
            wr_en   = 1'b1;
            wr_data = bv;
            if (best == idx_ff) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = best;
               state_in = ST_DN_RL;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_med_in   = med;
               out_cnt_in   = count;
               out_drop_in  = drop_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en && sel_ff == rmth_pkg::HEAP_LOWER) begin
         lower_mem[wr_addr] <= wr_data;
      end
      lo_rd_ff <= lower_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && sel_ff == rmth_pkg::HEAP_UPPER) begin
         upper_mem[wr_addr] <= wr_data;
      end
      up_rd_ff <= upper_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr == '0) begin
         if (sel_ff == rmth_pkg::HEAP_UPPER) begin
            utop_ff <= wr_data;
         end else begin
            ltop_ff <= wr_data;
         end
      end
      rd_sel_ff   <= sel_ff;
      sel_ff      <= sel_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      sample_ff   <= sample_in;
      lbuf_ff     <= lbuf_in;
      pend_ff     <= pend_in;
      has_r_ff    <= has_r_in;
      drop_ff     <= drop_in;
      out_med_ff  <= out_med_in;
      out_cnt_ff  <= out_cnt_in;
      out_drop_ff <= out_drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lsize_ff     <= '0;
         usize_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lsize_ff     <= lsize_in;
         usize_ff     <= usize_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(rmth_pkg::OUT_TDATA_W - MW - CW)'(0), out_cnt_ff, out_med_ff};
   assign rsp_tuser  = out_drop_ff;

endmodule

/* rtl/rmth_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the running median, bound to the top level
// depends on rmth_pkg and running_median_two_heaps
module rmth_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[43:33] <= rmth_pkg::MAX_COUNT)
      else $error("sample count beyond store size");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[43:33] == rmth_pkg::MAX_COUNT)
      else $error("drop reported with store not full");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[43:33] != '0)
      else $error("result word with empty store");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
